// ----- hdl/stable_sorted_priority_queue_unit_assert.svh -----
// Assertion macros for the sorted priority queue; clocked on clk, off in reset.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SSPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sspq_pkg.sv -----
package sspq_pkg;

  localparam int ID_W   = 31;
  localparam int URG_W  = 8;
  localparam int OCC_W  = 5;
  localparam int STAT_W = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

// ----- hdl/sspq_cell.sv -----
module sspq_cell #(
  parameter int UW = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sspq_pkg::cell_ctrl_t    ctrl,
  input  logic [sspq_pkg::ID_W-1:0] new_id,
  input  logic [UW-1:0]           new_urg,
  input  logic                    prev_ahead,
  input  logic                    prev_occ,
  input  logic [sspq_pkg::ID_W-1:0] prev_id,
  input  logic [UW-1:0]           prev_urg,
  input  logic                    next_occ,
  input  logic [sspq_pkg::ID_W-1:0] next_id,
  input  logic [UW-1:0]           next_urg,
  output logic                    ahead,
  output logic                    occ,
  output logic [sspq_pkg::ID_W-1:0] id,
  output logic [UW-1:0]           urg
);
  import sspq_pkg::*;

  logic            occ_r, occ_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic [UW-1:0]   urg_r, urg_nxt;

  // New entry goes ahead of this one: slot empty or its urgency strictly greater.
  assign ahead = !occ_r || (urg_r > new_urg);

  always_comb begin
    occ_nxt = occ_r;
    id_nxt  = id_r;
    urg_nxt = urg_r;
    priority if (ctrl.deq) begin
      occ_nxt = next_occ;
      id_nxt  = next_id;
      urg_nxt = next_urg;
    end else if (ctrl.enq && prev_ahead) begin
      occ_nxt = prev_occ;
      id_nxt  = prev_id;
      urg_nxt = prev_urg;
    end else if (ctrl.enq && ahead) begin
      occ_nxt = 1'b1;
      id_nxt  = new_id;
      urg_nxt = new_urg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    urg_r <= urg_nxt;
  end

  assign occ = occ_r;
  assign id  = id_r;
  assign urg = urg_r;

endmodule

// ----- hdl/stable_sorted_priority_queue_unit.sv -----
// Sorted priority queue of CAPACITY entries held in a row of cells, head in cell 0.
// Each request on in_ (tuser 0 enqueue, 1 dequeue) gives one result on out_. A lower
// urgency is served first and equal urgencies leave in arrival order. Every cell
// compares its entry with the incoming one and shifts or loads in the cycle of the
// transfer, so one request is taken per clock; the single output register is the only
// limit, and the input stalls only while a result waits and out_tready is low.
// Dequeue on an empty queue reports status 2; enqueue on a full queue is dropped with
// status 3. Occupancy shows the count after the request, modulo 32. No clearing pass.
`include "stable_sorted_priority_queue_unit_assert.svh"

module stable_sorted_priority_queue_unit #(
  parameter int CAPACITY     = 16,
  parameter int URGENCY_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [30:0] patient_id, [38:31] urgency, [39] zero
  input  logic [sspq_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] req_type
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [30:0] out_id, [38:31] out_urgency, [43:39] occupancy, [47:44] zero
  output logic [sspq_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [1:0] status
  output logic [sspq_pkg::STAT_W-1:0]      out_tuser
);
  import sspq_pkg::*;

  localparam int UW    = (URGENCY_BITS < URG_W) ? URGENCY_BITS : URG_W;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic             accept, full, empty, is_deq;
  cell_ctrl_t       ctrl;
  logic [ID_W-1:0]  new_id;
  logic [UW-1:0]    new_urg;

  logic             c_ahead  [CAPACITY];
  logic             c_occ    [CAPACITY];
  logic [ID_W-1:0]  c_id     [CAPACITY];
  logic [UW-1:0]    c_urg    [CAPACITY];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic [ID_W-1:0]  oid_r, oid_nxt;
  logic [URG_W-1:0] ourg_r, ourg_nxt;
  logic [OCC_W-1:0] occ_r;
  logic [CNT_W+OCC_W-1:0] count_ext;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_deq    = (in_tuser == REQ_DEQ);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign new_id    = in_tdata[ID_W-1:0];
  assign new_urg   = in_tdata[ID_W +: UW];

  assign ctrl.enq = accept && !is_deq && !full;
  assign ctrl.deq = accept && is_deq && !empty;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic            p_ahead, p_occ, n_occ;
      logic [ID_W-1:0] p_id, n_id;
      logic [UW-1:0]   p_urg, n_urg;

      if (g == 0) begin : g_head
        assign p_ahead  = 1'b0;
        assign p_occ    = 1'b0;
        assign p_id     = '0;
        assign p_urg    = '0;
      end else begin : g_mid
        assign p_ahead  = c_ahead[g-1];
        assign p_occ    = c_occ[g-1];
        assign p_id     = c_id[g-1];
        assign p_urg    = c_urg[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
        assign n_occ = 1'b0;
        assign n_id  = '0;
        assign n_urg = '0;
      end else begin : g_body
        assign n_occ = c_occ[g+1];
        assign n_id  = c_id[g+1];
        assign n_urg = c_urg[g+1];
      end

      sspq_cell #(.UW(UW)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_id     (new_id),
        .new_urg    (new_urg),
        .prev_ahead (p_ahead),
        .prev_occ   (p_occ),
        .prev_id    (p_id),
        .prev_urg   (p_urg),
        .next_occ   (n_occ),
        .next_id    (n_id),
        .next_urg   (n_urg),
        .ahead      (c_ahead[g]),
        .occ        (c_occ[g]),
        .id         (c_id[g]),
        .urg        (c_urg[g])
      );
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_ENQUEUED;
    oid_nxt    = '0;
    ourg_nxt   = '0;
    priority if (is_deq && empty) begin
      status_nxt = ST_EMPTY;
    end else if (is_deq) begin
      status_nxt = ST_DEQUEUED;
      oid_nxt    = c_id[0];
      ourg_nxt   = URG_W'(c_urg[0]);
      count_nxt  = count_r - 1'b1;
    end else if (full) begin
      status_nxt = ST_FULL;
    end else begin
      count_nxt  = count_r + 1'b1;
    end
  end

  assign count_ext = {{OCC_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      oid_r    <= oid_nxt;
      ourg_r   <= ourg_nxt;
      occ_r    <= count_ext[OCC_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {{(OUT_DATA_W - ID_W - URG_W - OCC_W){1'b0}}, occ_r, ourg_r, oid_r};

  `SSPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `SSPQ_ASSERT_NOW(a_head_occ, 1'b1, c_occ[0] == !empty, "head cell disagrees with count")
  `SSPQ_ASSERT_NOW(a_tail_occ, 1'b1, c_occ[CAPACITY-1] == full, "tail cell disagrees with count")
  `SSPQ_ASSERT_NEXT(a_full_drop, accept && !is_deq && full,
    out_tvalid && out_tuser == ST_FULL && count_r == $past(count_r), "full enqueue not dropped")

endmodule
